[rtl/itp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the infix-to-postfix converter
// Operator codes, command classes, error codes, character constants, the
// controller state type and the rank and symbol lookups.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Operator codes as held on the operator stack
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_SUB  = 3'd1,
      OP_MUL  = 3'd2,
      OP_DIV  = 3'd3,
      OP_OPEN = 3'd4
   } op_code_type;

   localparam int CODE_W = 3;

   // Class of one input word after decode
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_LETTER,
      CMD_OPER,
      CMD_OPEN,
      CMD_CLOSE,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      op_code_type  code;
      logic [7:0]   ch;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_POP
   } ctrl_state_type;

   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
   localparam logic [1:0] ERR_UNMATCHED = 2'd2;

   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;

   localparam logic [7:0] SYM_NONE = 8'h00;

   function automatic logic [1:0] op_rank(op_code_type code);
      logic [1:0] rank;
      case (code)
         OP_ADD, OP_SUB: rank = 2'd1;
         OP_MUL, OP_DIV: rank = 2'd2;
         default:        rank = 2'd0;
      endcase
      return rank;
   endfunction

   function automatic logic [7:0] op_symbol(op_code_type code);
      logic [7:0] sym;
      case (code)
         OP_ADD:  sym = CH_PLUS;
         OP_SUB:  sym = CH_MINUS;
         OP_MUL:  sym = CH_STAR;
         OP_DIV:  sym = CH_SLASH;
         default: sym = SYM_NONE;
      endcase
      return sym;
   endfunction

endpackage

[rtl/itp_stack_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_stack_ram: operator stack storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module itp_stack_ram #(
   parameter int DEPTH  = 64,
   parameter int DATA_W = 3
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/itp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_ctrl: shunting-yard sequencer
// Keeps the stack count, open-parenthesis count and a cached top entry,
// drives the stack memory and holds the result word register.
// ----------------------------------------------------------------------------
module itp_ctrl #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  itp_pkg::cmd_type               req_cmd,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_symbol,
   output logic                           rsp_last,
   output logic [1:0]                     rsp_error,
   output logic                           wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   output logic [itp_pkg::CODE_W-1:0]     wr_data,
   output logic                           rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   input  logic [itp_pkg::CODE_W-1:0]     rd_data
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

   itp_pkg::ctrl_state_type state_ff, state_in;
   itp_pkg::cmd_type        cmd_ff;
   itp_pkg::op_code_type    top_ff, top_in;
   logic [CW-1:0]           count_ff, count_in;
   logic [CW-1:0]           open_ff, open_in;

   logic                    rsp_valid_ff;
   logic [7:0]              rsp_symbol_ff;
   logic                    rsp_last_ff;
   logic [1:0]              rsp_error_ff;

   logic                    out_free;
   logic                    load_out;
   logic [7:0]              out_symbol;
   logic                    out_last;
   logic [1:0]              out_error;
   logic                    push_en;
   logic                    pop_en;
   logic                    flush_clear;

   logic                    has_top, full, ops_zero, top_pops_oper;
   logic                    has_next, popped_open, pop_emit, pop_go;
   logic                    ops_left_nz, oper_stop, close_last;
   itp_pkg::op_code_type    next_code;
   logic [CW-1:0]           open_after;

   // --- status terms ---------------------------------------------------------
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      has_top       = count_ff != '0;
      full          = count_ff == DEPTH_C;
      ops_zero      = count_ff == open_ff;
      top_pops_oper = has_top && (top_ff != itp_pkg::OP_OPEN) &&
                      (itp_pkg::op_rank(top_ff) >= itp_pkg::op_rank(cmd_ff.code));
      has_next      = count_ff > CW'(1);
      next_code     = itp_pkg::op_code_type'(rd_data);
      popped_open   = top_ff == itp_pkg::OP_OPEN;
      pop_emit      = !popped_open;
      pop_go        = !pop_emit || out_free;
      open_after    = open_ff - CW'(popped_open);
      ops_left_nz   = (count_ff - CW'(1)) != open_after;
      oper_stop     = !has_next || (next_code == itp_pkg::OP_OPEN) ||
                      (itp_pkg::op_rank(next_code) < itp_pkg::op_rank(cmd_ff.code));
      close_last    = has_next && (next_code == itp_pkg::OP_OPEN);
   end

   // --- next state -----------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itp_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = itp_pkg::ST_DISPATCH;
            end
         end
         itp_pkg::ST_DISPATCH: begin
            case (cmd_ff.kind)
               itp_pkg::CMD_LETTER: begin
                  if (out_free) state_in = itp_pkg::ST_IDLE;
               end
               itp_pkg::CMD_FLUSH: begin
                  if (!ops_zero) state_in = itp_pkg::ST_READ;
                  else if (out_free) state_in = itp_pkg::ST_IDLE;
               end
               itp_pkg::CMD_OPER: begin
                  if (top_pops_oper) state_in = itp_pkg::ST_READ;
                  else if (!full || out_free) state_in = itp_pkg::ST_IDLE;
               end
               itp_pkg::CMD_OPEN: begin
                  if (!full || out_free) state_in = itp_pkg::ST_IDLE;
               end
               itp_pkg::CMD_CLOSE: begin
                  if (open_ff != '0) state_in = itp_pkg::ST_READ;
                  else if (out_free) state_in = itp_pkg::ST_IDLE;
               end
               default: state_in = itp_pkg::ST_IDLE;
            endcase
         end
         itp_pkg::ST_READ: begin
            state_in = itp_pkg::ST_POP;
         end
         itp_pkg::ST_POP: begin
            if (pop_go) begin
               case (cmd_ff.kind)
                  itp_pkg::CMD_FLUSH:
                     state_in = ops_left_nz ? itp_pkg::ST_READ : itp_pkg::ST_IDLE;
                  itp_pkg::CMD_CLOSE:
                     state_in = popped_open ? itp_pkg::ST_IDLE : itp_pkg::ST_READ;
                  itp_pkg::CMD_OPER:
                     state_in = oper_stop ? itp_pkg::ST_DISPATCH : itp_pkg::ST_READ;
                  default:
                     state_in = itp_pkg::ST_IDLE;
               endcase
            end
         end
         default: state_in = itp_pkg::ST_IDLE;
      endcase
   end

   // --- outputs of the sequencer ---------------------------------------------
   always_comb begin
      req_ready   = 1'b0;
      load_out    = 1'b0;
      out_symbol  = itp_pkg::SYM_NONE;
      out_last    = 1'b0;
      out_error   = itp_pkg::ERR_NONE;
      push_en     = 1'b0;
      pop_en      = 1'b0;
      rd_en       = 1'b0;
      flush_clear = 1'b0;
      case (state_ff)
         itp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         itp_pkg::ST_DISPATCH: begin
            case (cmd_ff.kind)
               itp_pkg::CMD_LETTER: begin
                  load_out   = out_free;
                  out_symbol = cmd_ff.ch;
                  out_last   = 1'b1;
               end
               itp_pkg::CMD_FLUSH: begin
                  if (ops_zero) begin
                     load_out    = out_free;
                     out_last    = 1'b1;
                     flush_clear = out_free;
                  end
               end
               itp_pkg::CMD_OPER, itp_pkg::CMD_OPEN: begin
                  if (!(cmd_ff.kind == itp_pkg::CMD_OPER && top_pops_oper)) begin
                     if (full) begin
                        load_out  = out_free;
                        out_last  = 1'b1;
                        out_error = itp_pkg::ERR_OVERFLOW;
                     end else begin
                        push_en = 1'b1;
                     end
                  end
               end
               itp_pkg::CMD_CLOSE: begin
                  if (open_ff == '0) begin
                     load_out  = out_free;
                     out_last  = 1'b1;
                     out_error = itp_pkg::ERR_UNMATCHED;
                  end
               end
               default: begin
               end
            endcase
         end
         itp_pkg::ST_READ: begin
            rd_en = 1'b1;
         end
         itp_pkg::ST_POP: begin
            pop_en     = pop_go;
            load_out   = pop_go && pop_emit;
            out_symbol = itp_pkg::op_symbol(top_ff);
            case (cmd_ff.kind)
               itp_pkg::CMD_FLUSH: out_last = !ops_left_nz;
               itp_pkg::CMD_CLOSE: out_last = close_last;
               itp_pkg::CMD_OPER:  out_last = oper_stop;
               default:            out_last = 1'b0;
            endcase
            flush_clear = pop_go && (cmd_ff.kind == itp_pkg::CMD_FLUSH) && !ops_left_nz;
         end
         default: begin
         end
      endcase
   end

   // --- stack bookkeeping ----------------------------------------------------
   always_comb begin
      count_in = count_ff;
      open_in  = open_ff;
      top_in   = top_ff;
      if (flush_clear) begin
         count_in = '0;
         open_in  = '0;
      end else if (pop_en) begin
         count_in = count_ff - CW'(1);
         open_in  = open_after;
         top_in   = next_code;
      end else if (push_en) begin
         count_in = count_ff + CW'(1);
         open_in  = open_ff + CW'(cmd_ff.code == itp_pkg::OP_OPEN);
         top_in   = cmd_ff.code;
      end
   end

   assign wr_en   = push_en;
   assign wr_addr = count_ff[AW-1:0];
   assign wr_data = cmd_ff.code;
   assign rd_addr = AW'(count_ff - CW'(2));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itp_pkg::ST_IDLE;
         count_ff <= '0;
         open_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      if (req_valid && req_ready) begin
         cmd_ff <= req_cmd;
      end
   end

   // --- result word register -------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_symbol_ff <= out_symbol;
         rsp_last_ff   <= out_last;
         rsp_error_ff  <= out_error;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_symbol = rsp_symbol_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_error  = rsp_error_ff;

   // --- assertions -----------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("stack count beyond depth");

   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= count_ff)
      else $error("open parenthesis count exceeds stack count");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_en |-> (count_ff < DEPTH_C))
      else $error("push onto full stack");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   a_close_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == itp_pkg::ST_POP && cmd_ff.kind == itp_pkg::CMD_CLOSE) |->
      (open_ff != '0))
      else $error("close parenthesis pop without open parenthesis on stack");

endmodule

[rtl/infix_to_postfix_converter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit: streaming shunting-yard converter
// Takes an infix expression one character word at a time and returns the
// postfix form, one symbol word per result.
// ----------------------------------------------------------------------------
// Letters come out at once, + - * / and '(' go onto an operator stack in a
// single-port-read synchronous memory, ')' pops to its matching '(' and an
// end-of-expression word (req_kind = 1) flushes the stack. The last result
// caused by one input word carries rsp_last. A push onto a full stack gives a
// result with rsp_error = 1, a ')' with no '(' held gives rsp_error = 2, and a
// flush that returns no operator gives one marker word with symbol 0. Other
// characters give nothing. Timing: one word is worked on at a time. A letter,
// a push or an error result passes through accept and dispatch; every stack
// pop adds a memory read of the entry below the top, then the pop itself, so
// an operator that pops entries goes back to dispatch for its push, and a ')'
// pops each operator above its '(' and then removes the '(' itself. The
// memory read latency sets the pop rate. The result register lets the next
// word be accepted while a result still waits on rsp_ready. No clearing pass
// is needed after reset: only entries below the stack count are read.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit #(
   parameter int STACK_DEPTH = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_kind,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last,
   output logic [1:0] rsp_error
);

   localparam int AW = $clog2(STACK_DEPTH);

   itp_pkg::cmd_type              req_cmd;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [itp_pkg::CODE_W-1:0]    wr_data;
   logic                          rd_en;
   logic [AW-1:0]                 rd_addr;
   logic [itp_pkg::CODE_W-1:0]    rd_data;

   // Classify the incoming word: letter, operator, parenthesis, flush or
   // ignored character.
   always_comb begin
      req_cmd.kind = itp_pkg::CMD_NONE;
      req_cmd.code = itp_pkg::OP_ADD;
      req_cmd.ch   = req_char_in;
      if (req_kind) begin
         req_cmd.kind = itp_pkg::CMD_FLUSH;
      end else if (req_char_in inside {[itp_pkg::CH_LOWER_A:itp_pkg::CH_LOWER_Z],
                                       [itp_pkg::CH_UPPER_A:itp_pkg::CH_UPPER_Z]}) begin
         req_cmd.kind = itp_pkg::CMD_LETTER;
      end else begin
         case (req_char_in)
            itp_pkg::CH_PLUS: begin
               req_cmd.kind = itp_pkg::CMD_OPER;
               req_cmd.code = itp_pkg::OP_ADD;
            end
            itp_pkg::CH_MINUS: begin
               req_cmd.kind = itp_pkg::CMD_OPER;
               req_cmd.code = itp_pkg::OP_SUB;
            end
            itp_pkg::CH_STAR: begin
               req_cmd.kind = itp_pkg::CMD_OPER;
               req_cmd.code = itp_pkg::OP_MUL;
            end
            itp_pkg::CH_SLASH: begin
               req_cmd.kind = itp_pkg::CMD_OPER;
               req_cmd.code = itp_pkg::OP_DIV;
            end
            itp_pkg::CH_LPAREN: begin
               req_cmd.kind = itp_pkg::CMD_OPEN;
               req_cmd.code = itp_pkg::OP_OPEN;
            end
            itp_pkg::CH_RPAREN: begin
               req_cmd.kind = itp_pkg::CMD_CLOSE;
            end
            // '#' is an ordinary ignored character here
            itp_pkg::CH_HASH: begin
               req_cmd.kind = itp_pkg::CMD_NONE;
            end
            default: begin
               req_cmd.kind = itp_pkg::CMD_NONE;
            end
         endcase
      end
   end

   // Sequencer: stack count, cached top, result register
   itp_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   // Operator stack storage
   itp_stack_ram #(
      .DEPTH  (STACK_DEPTH),
      .DATA_W (itp_pkg::CODE_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

[test/infix_to_postfix_converter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_unit_tb: self-checking bench of the converter
// Feeds infix character words and end-of-expression words through the request
// channel and checks every result word against a shunting-yard predictor kept
// in the bench. It starts with a short directed list, then runs random
// expressions (mostly well formed, some broken, some noise) through four
// flow-control phases, deep nesting runs that overflow the operator stack,
// and a long result stall that backs the block up.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_unit_tb;

   localparam int DEPTH      = 64;
   localparam int PHASE_GOAL = 105;   // counted words per random phase
   localparam int HOLD_CYC   = 400;   // long receiver hold-off
   localparam int TAIL_CYC   = 40;    // quiet cycles after the last result

   // One request word and one result word as the bench sees them
   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
   } in_word_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
      logic [1:0] error;
   } out_word_type;

   // Clock, reset and DUT ports; every input has a known value from time 0
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic       req_kind    = 1'b0;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [7:0] rsp_symbol;
   logic       rsp_last;
   logic [1:0] rsp_error;

   // Flow-control knobs, set by the sequencer at clock edges
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   logic rsp_hold       = 1'b0;

   // Words waiting for the driver and result words waiting for the DUT
   in_word_type  char_feed_q[$];
   out_word_type postfix_expect_q[$];
   in_word_type  feed_word;

   // Shadow operator stack of the predictor
   itp_pkg::op_code_type shadow_ops[DEPTH];
   int                   shadow_depth = 0;

   // Generator state and run statistics
   int break_pct    = 0;
   int gen_count    = 0;
   int words_in     = 0;
   int words_out    = 0;
   int bad_count    = 0;
   int ovf_seen     = 0;
   int unmatch_seen = 0;
   int marker_seen  = 0;

   infix_to_postfix_converter_unit #(
      .STACK_DEPTH(DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_char_in(req_char_in),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_symbol (rsp_symbol),
      .rsp_last   (rsp_last),
      .rsp_error  (rsp_error)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor: shunting-yard on the shadow stack
   // ------------------------------------------------------------------------
   function automatic out_word_type make_word(logic [7:0] sym, logic [1:0] err);
      out_word_type w;
      w.symbol = sym;
      w.last   = 1'b0;
      w.error  = err;
      return w;
   endfunction

   function automatic logic [1:0] op_weight(itp_pkg::op_code_type c);
      if (c == itp_pkg::OP_MUL || c == itp_pkg::OP_DIV) return 2'd2;
      if (c == itp_pkg::OP_OPEN) return 2'd0;
      return 2'd1;
   endfunction

   function automatic logic [7:0] op_char(itp_pkg::op_code_type c);
      case (c)
         itp_pkg::OP_ADD: return itp_pkg::CH_PLUS;
         itp_pkg::OP_SUB: return itp_pkg::CH_MINUS;
         itp_pkg::OP_MUL: return itp_pkg::CH_STAR;
         itp_pkg::OP_DIV: return itp_pkg::CH_SLASH;
         default:         return itp_pkg::SYM_NONE;
      endcase
   endfunction

   function automatic logic is_letter(logic [7:0] ch);
      return (ch >= itp_pkg::CH_LOWER_A && ch <= itp_pkg::CH_LOWER_Z) ||
             (ch >= itp_pkg::CH_UPPER_A && ch <= itp_pkg::CH_UPPER_Z);
   endfunction

   function automatic void predict_postfix(logic kind, logic [7:0] ch);
      out_word_type         step_q[$];
      itp_pkg::op_code_type code;
      logic                 is_op;
      logic                 found;
      is_op = 1'b1;
      found = 1'b0;
      case (ch)
         itp_pkg::CH_PLUS:  code = itp_pkg::OP_ADD;
         itp_pkg::CH_MINUS: code = itp_pkg::OP_SUB;
         itp_pkg::CH_STAR:  code = itp_pkg::OP_MUL;
         itp_pkg::CH_SLASH: code = itp_pkg::OP_DIV;
         default: begin
            code  = itp_pkg::OP_OPEN;
            is_op = 1'b0;
         end
      endcase

      if (kind) begin
         // Flush: drop open parens, emit the rest top first
         while (shadow_depth > 0) begin
            shadow_depth--;
            if (shadow_ops[shadow_depth] != itp_pkg::OP_OPEN)
               step_q.push_back(make_word(op_char(shadow_ops[shadow_depth]),
                                          itp_pkg::ERR_NONE));
         end
         if (step_q.size() == 0)
            step_q.push_back(make_word(itp_pkg::SYM_NONE, itp_pkg::ERR_NONE));
      end else if (is_letter(ch)) begin
         step_q.push_back(make_word(ch, itp_pkg::ERR_NONE));
      end else if (is_op || ch == itp_pkg::CH_LPAREN) begin
         // Operators pop everything of equal or higher rank down to a paren
         if (is_op) begin
            while (shadow_depth > 0 && shadow_ops[shadow_depth-1] != itp_pkg::OP_OPEN &&
                   op_weight(shadow_ops[shadow_depth-1]) >= op_weight(code)) begin
               step_q.push_back(make_word(op_char(shadow_ops[shadow_depth-1]),
                                          itp_pkg::ERR_NONE));
               shadow_depth--;
            end
         end
         if (shadow_depth < DEPTH) begin
            shadow_ops[shadow_depth] = code;
            shadow_depth++;
         end else begin
            step_q.push_back(make_word(itp_pkg::SYM_NONE, itp_pkg::ERR_OVERFLOW));
         end
      end else if (ch == itp_pkg::CH_RPAREN) begin
         for (int i = 0; i < shadow_depth; i++)
            if (shadow_ops[i] == itp_pkg::OP_OPEN) found = 1'b1;
         if (!found) begin
            step_q.push_back(make_word(itp_pkg::SYM_NONE, itp_pkg::ERR_UNMATCHED));
         end else begin
            while (shadow_depth > 0) begin
               shadow_depth--;
               if (shadow_ops[shadow_depth] == itp_pkg::OP_OPEN) break;
               step_q.push_back(make_word(op_char(shadow_ops[shadow_depth]),
                                          itp_pkg::ERR_NONE));
            end
         end
      end

      if (step_q.size() != 0) step_q[step_q.size()-1].last = 1'b1;
      foreach (step_q[i]) postfix_expect_q.push_back(step_q[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus generators: they only fill the feed queue
   // ------------------------------------------------------------------------
   function automatic void add_word(logic kind, logic [7:0] ch, logic counted);
      in_word_type w;
      w.kind = kind;
      w.ch   = ch;
      char_feed_q.push_back(w);
      if (counted) gen_count++;
   endfunction

   function automatic logic [7:0] rand_letter();
      if ($urandom_range(1)) return itp_pkg::CH_LOWER_A + 8'($urandom_range(25));
      return itp_pkg::CH_UPPER_A + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] rand_op();
      case ($urandom_range(3))
         0:       return itp_pkg::CH_PLUS;
         1:       return itp_pkg::CH_MINUS;
         2:       return itp_pkg::CH_STAR;
         default: return itp_pkg::CH_SLASH;
      endcase
   endfunction

   function automatic void gen_term(int lvl);
      if (lvl > 0 && $urandom_range(2) == 0) begin
         if ($urandom_range(99) >= break_pct) add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
         gen_expr(lvl - 1);
         if ($urandom_range(99) >= break_pct) add_word(1'b0, itp_pkg::CH_RPAREN, 1'b1);
      end else begin
         add_word(1'b0, rand_letter(), 1'b1);
      end
      // broken expressions also get stray parens
      if ($urandom_range(99) < break_pct)
         add_word(1'b0, $urandom_range(1) ? itp_pkg::CH_RPAREN : itp_pkg::CH_LPAREN,
                  1'b1);
   endfunction

   function automatic void gen_expr(int lvl);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i != 0) add_word(1'b0, rand_op(), 1'b1);
         gen_term(lvl);
      end
   endfunction

   // Nesting deep enough to fill the stack and push past it
   function automatic void gen_deep_fill(logic opens_only);
      if (opens_only) begin
         for (int i = 0; i < DEPTH; i++) add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
         add_word(1'b0, itp_pkg::CH_MINUS, 1'b1);
         add_word(1'b0, itp_pkg::CH_RPAREN, 1'b1);
      end else begin
         for (int i = 0; i < DEPTH / 2; i++) begin
            add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
            add_word(1'b0, rand_op(), 1'b1);
         end
         add_word(1'b0, itp_pkg::CH_STAR, 1'b1);
         add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
         add_word(1'b0, itp_pkg::CH_RPAREN, 1'b1);
         add_word(1'b0, rand_letter(), 1'b1);
      end
      add_word(1'b1, 8'($urandom_range(255)), 1'b1);
   endfunction

   function automatic void gen_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) begin
         break_pct = 0;
         gen_expr($urandom_range(3));
         add_word(1'b1, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 82) begin
         break_pct = 15;
         gen_expr($urandom_range(1, 3));
         add_word(1'b1, 8'($urandom_range(255)), 1'b1);
      end else if (pick < 94) begin
         // noise: any byte, which the block mostly ignores
         for (int i = $urandom_range(1, 4); i > 0; i--)
            add_word(1'b0, 8'($urandom_range(255)), 1'b1);
      end else begin
         add_word(1'($urandom_range(1)),
                  $urandom_range(1) ? itp_pkg::CH_RPAREN : itp_pkg::CH_HASH, 1'b1);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Driver: present the next word; hold it until it is taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (char_feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            feed_word    = char_feed_q.pop_front();
            req_valid   <= 1'b1;
            req_kind    <= feed_word.kind;
            req_char_in <= feed_word.ch;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: predict on every accepted request word, then check every
   // accepted result word against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_postfix(req_kind, req_char_in);
            words_in++;
         end

         if (rsp_valid && rsp_ready) begin
            words_out++;
            if (postfix_expect_q.size() == 0) begin
               bad_count++;
               if (bad_count <= 10)
                  $display("unexpected result word %0d: symbol %02h last %0b error %0d",
                           words_out, rsp_symbol, rsp_last, rsp_error);
            end else begin
               out_word_type want;
               want = postfix_expect_q.pop_front();
               if (want.error == itp_pkg::ERR_OVERFLOW) ovf_seen++;
               if (want.error == itp_pkg::ERR_UNMATCHED) unmatch_seen++;
               if (want.error == itp_pkg::ERR_NONE && want.symbol == itp_pkg::SYM_NONE)
                  marker_seen++;
               if (rsp_symbol !== want.symbol || rsp_last !== want.last ||
                   rsp_error !== want.error) begin
                  bad_count++;
                  if (bad_count <= 10) begin
                     $write("mismatch at result word %0d: expected symbol %02h last %0b ",
                            words_out, want.symbol, want.last);
                     $display("error %0d, got symbol %02h last %0b error %0d",
                              want.error, rsp_symbol, rsp_last, rsp_error);
                  end
               end
            end
         end

         // Stall the result side at random, or fully during a hold-off
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Sequencer: reset, directed words, then the random phases
   // ------------------------------------------------------------------------
   task automatic drain_all();
      while (char_feed_q.size() != 0 || req_valid || postfix_expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_flow(int send_pct, int recv_pct);
      @(posedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
   endtask

   initial begin
      int phase_start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty flush, unmatched close, ignored bytes, letter
      // extremes, every operator, a nested group, open parens left at flush
      add_word(1'b1, itp_pkg::CH_PLUS, 1'b1);
      add_word(1'b0, itp_pkg::CH_RPAREN, 1'b1);
      add_word(1'b0, itp_pkg::CH_HASH, 1'b0);
      add_word(1'b0, 8'h00, 1'b0);
      add_word(1'b0, 8'hFF, 1'b0);
      add_word(1'b0, itp_pkg::CH_LOWER_A, 1'b1);
      add_word(1'b0, itp_pkg::CH_PLUS, 1'b1);
      add_word(1'b0, itp_pkg::CH_UPPER_Z, 1'b1);
      add_word(1'b0, itp_pkg::CH_STAR, 1'b1);
      add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
      add_word(1'b0, itp_pkg::CH_LOWER_Z, 1'b1);
      add_word(1'b0, itp_pkg::CH_MINUS, 1'b1);
      add_word(1'b0, itp_pkg::CH_UPPER_A, 1'b1);
      add_word(1'b0, itp_pkg::CH_RPAREN, 1'b1);
      add_word(1'b0, itp_pkg::CH_SLASH, 1'b1);
      add_word(1'b0, itp_pkg::CH_LOWER_A + 8'd1, 1'b1);
      add_word(1'b0, itp_pkg::CH_MINUS, 1'b1);
      add_word(1'b0, itp_pkg::CH_UPPER_A + 8'd2, 1'b1);
      add_word(1'b1, 8'h00, 1'b1);
      add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
      add_word(1'b0, itp_pkg::CH_LPAREN, 1'b1);
      add_word(1'b1, 8'hFF, 1'b1);
      drain_all();

      // Phase: no idling on either side, with a long result hold-off while
      // the sender keeps offering words (two letters up front back the block
      // up for sure), then an overflow run
      set_flow(0, 0);
      phase_start = gen_count;
      rsp_hold <= 1'b1;
      add_word(1'b0, rand_letter(), 1'b1);
      add_word(1'b0, rand_letter(), 1'b1);
      repeat (3) gen_sequence();
      repeat (HOLD_CYC) @(posedge clock);
      rsp_hold <= 1'b0;
      gen_deep_fill(1'b0);
      while (gen_count - phase_start < PHASE_GOAL) gen_sequence();
      drain_all();

      // Phase: sender mostly idle
      set_flow(82, 0);
      phase_start = gen_count;
      while (gen_count - phase_start < PHASE_GOAL) gen_sequence();
      drain_all();

      // Phase: receiver mostly stalled, with an all-open-paren overflow
      set_flow(0, 82);
      phase_start = gen_count;
      gen_deep_fill(1'b1);
      while (gen_count - phase_start < PHASE_GOAL) gen_sequence();
      drain_all();

      // Phase: light idling on both sides
      set_flow(7, 7);
      phase_start = gen_count;
      while (gen_count - phase_start < PHASE_GOAL) gen_sequence();
      drain_all();

      // Let any stray result show up before closing the books
      repeat (TAIL_CYC) @(posedge clock);
      if (postfix_expect_q.size() != 0) begin
         bad_count++;
         $display("%0d expected result words never arrived", postfix_expect_q.size());
      end

      $display("Converted %0d request words into %0d result words; %0d mismatches.",
               words_in, words_out, bad_count);
      $display("Seen: %0d stack overflows, %0d unmatched closes, %0d empty flushes.",
               ovf_seen, unmatch_seen, marker_seen);
      if (bad_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
